// ===== hw/rtl/tac_pkg.sv =====
// Package for the touch affine calibration unit.
// Holds widths, register indexes, shared structs and the divider step function.
// No dependencies.
`timescale 1ns / 1ps

package tac_pkg;

  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 32;
  localparam int CoefW      = 32;
  localparam int RawW       = 16;
  localparam int TimeW      = 32;
  localparam int GapW       = 16;
  localparam int CalW       = 16;
  localparam int ProdW      = CoefW + RawW + 1;
  localparam int SumW       = ProdW + 1;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;
  localparam int MulSteps   = 4;
  localparam int MulCntW    = 3;
  localparam int DivBitsPerCycle = 2;
  localparam int DivCycles  = SumW / DivBitsPerCycle;
  localparam int DivCntW    = 5;

  localparam logic [GapW-1:0] PollGapReset = GapW'(100);

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A   = 4'd0,
    REG_COEF_B   = 4'd1,
    REG_COEF_C   = 4'd2,
    REG_COEF_D   = 4'd3,
    REG_COEF_E   = 4'd4,
    REG_COEF_F   = 4'd5,
    REG_DIVISOR  = 4'd6,
    REG_POLL_GAP = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
    logic signed [CoefW-1:0] coef_d;
    logic signed [CoefW-1:0] coef_e;
    logic signed [CoefW-1:0] coef_f;
    logic signed [CoefW-1:0] divisor;
  } coef_t;

  typedef struct packed {
    logic [CoefW-1:0] rem;
    logic [SumW-1:0]  num;
  } div_state_t;

  // One restoring division step: the dividend shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  function automatic div_state_t div_step(div_state_t s, logic [CoefW-1:0] den);
    logic [CoefW:0] trial;
    div_state_t     r;
    trial = {s.rem, s.num[SumW-1]};
    r.num = {s.num[SumW-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      trial    = trial - {1'b0, den};
      r.num[0] = 1'b1;
    end
    r.rem = trial[CoefW-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/tac_front.sv =====
// Front end of the touch affine calibration unit.
// Accepts samples, checks the poll time and press flag, and queues passing items.
// Depends on tac_pkg.
`timescale 1ns / 1ps

module tac_front import tac_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [TimeW-1:0] time_now,
  input  logic             pressed,
  input  logic [RawW-1:0]  raw_x,
  input  logic [RawW-1:0]  raw_y,
  input  logic [GapW-1:0]  poll_gap,
  output logic             push,
  output sample_t          push_data,
  input  logic             push_ready
);

  logic [TimeW-1:0] next_poll_time;
  logic             pass;
  logic             take;

  assign in_ready  = push_ready;
  assign take      = in_valid && in_ready;
  assign pass      = (next_poll_time < time_now) && pressed;
  assign push      = take && pass;
  assign push_data = '{raw_x: raw_x, raw_y: raw_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      next_poll_time <= '0;
    end else if (push) begin
      next_poll_time <= time_now + {{(TimeW-GapW){1'b0}}, poll_gap};
    end
  end

`ifndef SYNTHESIS
  a_poll_update: assert property (@(posedge clk) disable iff (rst)
    push |=> next_poll_time == $past(time_now + {{(TimeW-GapW){1'b0}}, poll_gap}))
    else $error("next poll time not updated after a passing item");
`endif

endmodule

// ===== hw/rtl/tac_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
// Depends on tac_pkg.
`timescale 1ns / 1ps

module tac_queue import tac_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  sample_t push_data,
  output logic    push_ready,
  output logic    pop_valid,
  input  logic    pop,
  output sample_t pop_data
);

  sample_t              mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign push_ready = count != QueueCntW'(QueueDepth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != QueueCntW'(QueueDepth))
    else $error("item pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("item popped from an empty queue");
`endif

endmodule

// ===== hw/rtl/tac_back.sv =====
// Arithmetic back end of the touch affine calibration unit.
// Forms both affine sums on a shared multiplier, divides them with two
// sequential signed dividers and holds the result in an output register.
// Depends on tac_pkg.
`timescale 1ns / 1ps

module tac_back import tac_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  coef_t           coef,
  input  logic            pop_valid,
  output logic            pop,
  input  sample_t         pop_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CalW-1:0] cal_x,
  output logic [CalW-1:0] cal_y
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                 state;
  sample_t                sample;
  logic [MulCntW-1:0]     mstep;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_next;
  logic signed [CoefW-1:0] mul_a;
  logic signed [RawW:0]    mul_b;
  logic [SumW-1:0]        acc_x;
  logic [SumW-1:0]        acc_y;
  logic [SumW-1:0]        prod_ext;
  logic [CoefW-1:0]       den;
  logic                   neg_x;
  logic                   neg_y;
  div_state_t             div_x;
  div_state_t             div_y;
  div_state_t             div_x_next;
  div_state_t             div_y_next;
  logic [DivCntW-1:0]     dcnt;
  logic                   load_out;
  logic [CalW-1:0]        q_x;
  logic [CalW-1:0]        q_y;

  assign pop = pop_valid && (state == S_IDLE);

  always_comb begin
    case (mstep)
      3'd0: begin
        mul_a = coef.coef_a;
        mul_b = signed'({1'b0, sample.raw_x});
      end
      3'd1: begin
        mul_a = coef.coef_b;
        mul_b = signed'({1'b0, sample.raw_y});
      end
      3'd2: begin
        mul_a = coef.coef_d;
        mul_b = signed'({1'b0, sample.raw_x});
      end
      default: begin
        mul_a = coef.coef_e;
        mul_b = signed'({1'b0, sample.raw_y});
      end
    endcase
    prod_next = mul_a * mul_b;
  end

  assign prod_ext = {prod[ProdW-1], prod};

  always_comb begin
    div_x_next = div_x;
    div_y_next = div_y;
    for (int i = 0; i < DivBitsPerCycle; i++) begin
      div_x_next = div_step(div_x_next, den);
      div_y_next = div_step(div_y_next, den);
    end
  end

  assign load_out = (state == S_DONE) && (!out_valid || out_ready);
  assign q_x      = div_x.num[CalW-1:0];
  assign q_y      = div_y.num[CalW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstep <= '0;
      dcnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mstep <= mstep + 1'b1;
          if (mstep == MulCntW'(MulSteps)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == DivCntW'(DivCycles - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sample <= pop_data;
        acc_x  <= {{(SumW-CoefW){coef.coef_c[CoefW-1]}}, coef.coef_c};
        acc_y  <= {{(SumW-CoefW){coef.coef_f[CoefW-1]}}, coef.coef_f};
      end
      S_MUL: begin
        prod <= prod_next;
        if (mstep == 3'd1 || mstep == 3'd2) begin
          acc_x <= acc_x + prod_ext;
        end else if (mstep == 3'd3 || mstep == 3'd4) begin
          acc_y <= acc_y + prod_ext;
        end
      end
      S_PREP: begin
        div_x.rem <= '0;
        div_y.rem <= '0;
        div_x.num <= acc_x[SumW-1] ? -acc_x : acc_x;
        div_y.num <= acc_y[SumW-1] ? -acc_y : acc_y;
        neg_x     <= acc_x[SumW-1] ^ coef.divisor[CoefW-1];
        neg_y     <= acc_y[SumW-1] ^ coef.divisor[CoefW-1];
        den       <= coef.divisor[CoefW-1] ? -coef.divisor : coef.divisor;
      end
      S_DIV: begin
        div_x <= div_x_next;
        div_y <= div_y_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cal_x <= neg_x ? -q_x : q_x;
      cal_y <= neg_y ? -q_y : q_y;
    end
  end

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != '0)
    else $error("divider running with a zero divisor");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_MUL)
    else $error("back end did not start multiplying after taking an item");
`endif

endmodule

// ===== hw/rtl/touch_affine_calibrate_unit.sv =====
// Touch affine calibration unit: top level with the register file.
// Instantiates tac_front, tac_queue and tac_back; depends on tac_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one touch sample per item:
//   time_now, pressed, raw_x, raw_y. An item passes when the stored next
//   poll time is below time_now and pressed is set; the next poll time then
//   becomes time_now + poll_gap. Items that do not pass are consumed and
//   give no result.
//   Output channel (out_valid/out_ready) carries cal_x and cal_y, the low
//   16 bits of (A*rx + B*ry + C)/div and (D*rx + E*ry + F)/div, truncated.
//   Configuration: cfg_we writes cfg_data into register cfg_index;
//   indexes past the list and zero divisor writes are ignored.
//   An accepted input passes through the queue, four shared multiplier
//   products with a trailing accumulate, a sign step, the divider at two
//   quotient bits per cycle and the output register. The back end takes a
//   new passing item only once the last result is in the output register;
//   failing items are dropped at the input and never enter the queue.
//   A two-entry queue keeps accepting while the result waits; when the
//   receiver stalls the result is held and input stalls once the queue fills.
//   Reset restores the register defaults and clears the next poll time.
`timescale 1ns / 1ps

module touch_affine_calibrate_unit import tac_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TimeW-1:0]    time_now,
  input  logic                pressed,
  input  logic [RawW-1:0]     raw_x,
  input  logic [RawW-1:0]     raw_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CalW-1:0]     cal_x,
  output logic [CalW-1:0]     cal_y,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  coef_t           coef;
  logic [GapW-1:0] poll_gap;
  logic            push;
  logic            push_ready;
  sample_t         push_data;
  logic            pop;
  logic            pop_valid;
  sample_t         pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.coef_a  <= CoefW'(1);
      coef.coef_b  <= '0;
      coef.coef_c  <= '0;
      coef.coef_d  <= CoefW'(1);
      coef.coef_e  <= '0;
      coef.coef_f  <= '0;
      coef.divisor <= CoefW'(1);
      poll_gap     <= PollGapReset;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF_A: coef.coef_a <= cfg_data;
        REG_COEF_B: coef.coef_b <= cfg_data;
        REG_COEF_C: coef.coef_c <= cfg_data;
        REG_COEF_D: coef.coef_d <= cfg_data;
        REG_COEF_E: coef.coef_e <= cfg_data;
        REG_COEF_F: coef.coef_f <= cfg_data;
        REG_DIVISOR: begin
          if (cfg_data != '0) begin
            coef.divisor <= cfg_data;
          end
        end
        REG_POLL_GAP: poll_gap <= cfg_data[GapW-1:0];
        default: begin
        end
      endcase
    end
  end

  tac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .time_now   (time_now),
    .pressed    (pressed),
    .raw_x      (raw_x),
    .raw_y      (raw_y),
    .poll_gap   (poll_gap),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  tac_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  tac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cal_x     (cal_x),
    .cal_y     (cal_y)
  );

endmodule

// ===== dv/touch_affine_calibrate_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for touch_affine_calibrate_unit: sends touch samples and register writes,
// predicts each calibrated point and compares every result in order.
// Depends on tac_pkg and the RTL of the unit.

module touch_affine_calibrate_unit_tb;
  import tac_pkg::*;

  localparam int     PhaseCount  = 8;
  localparam int     PhaseItems  = 155;
  localparam int     DrainCycles = 64;
  localparam int     MaxWait     = 16;
  localparam longint CycleLimit  = 600000;

  localparam logic [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  typedef struct {
    logic [TimeW-1:0] time_now;
    logic             pressed;
    logic [RawW-1:0]  raw_x;
    logic [RawW-1:0]  raw_y;
  } touch_t;

  typedef struct {
    logic [CalW-1:0] cal_x;
    logic [CalW-1:0] cal_y;
  } point_t;

  typedef struct {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [TimeW-1:0]    time_now  = '0;
  logic                pressed   = 1'b0;
  logic [RawW-1:0]     raw_x     = '0;
  logic [RawW-1:0]     raw_y     = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CalW-1:0]     cal_x;
  logic [CalW-1:0]     cal_y;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  touch_t     sample_q[$];
  point_t     cal_q[$];
  reg_write_t reg_q[$];
  touch_t     next_touch;

  coef_t            coefs;
  logic [GapW-1:0]  gap_ticks;
  logic [TimeW-1:0] next_poll;
  // The stimulus side keeps its own view of the poll time so that it can
  // aim sample times just past it.
  logic [TimeW-1:0] stim_next_poll;

  bit     in_idle_on  = 1'b1;
  bit     out_idle_on = 1'b1;
  bit     in_taken    = 1'b0;
  int     in_wait     = 0;
  int     out_wait    = 0;
  int     errors      = 0;
  longint cycles      = 0;

  touch_affine_calibrate_unit dut (.*);

  always #1 clk = ~clk;

  function automatic int draw_wait(input bit on);
    return on ? $urandom_range(0, MaxWait) : 0;
  endfunction

  function automatic logic [CalW-1:0] affine_axis(
    input logic signed [CoefW-1:0] wx, wy, off, div,
    input logic [RawW-1:0]         rx, ry
  );
    longint sum;
    longint quo;
    sum = longint'(wx) * longint'(rx) + longint'(wy) * longint'(ry) + longint'(off);
    quo = sum / longint'(div);
    return quo[CalW-1:0];
  endfunction

  function automatic logic [RawW-1:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return RawW'($urandom);
    endcase
  endfunction

  function automatic logic [CoefW-1:0] rand_coef(input bit narrow);
    case ($urandom_range(0, 11))
      0: return CoefMax;
      1: return CoefMin;
      2: return '0;
      default: return narrow ? CoefW'($urandom_range(0, 600)) - CoefW'(300) : CoefW'($urandom);
    endcase
  endfunction

  function automatic logic [CoefW-1:0] rand_divisor(input bit narrow);
    logic [CoefW-1:0] d;
    d = narrow ? CoefW'($urandom_range(1, 512)) : CoefW'($urandom);
    case ($urandom_range(0, 7))
      0: d = CoefMax;
      1: d = CoefMin;
      2: d = '1;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) d = -d;
    return d;
  endfunction

  function automatic logic [CfgDataW-1:0] rand_gap();
    logic [CfgDataW-1:0] g;
    g = $urandom;
    case ($urandom_range(0, 3))
      0: g[GapW-1:0] = '0;
      1: g[GapW-1:0] = '1;
      2: g[GapW-1:0] = GapW'($urandom_range(1, 300));
      default: ;
    endcase
    return g;
  endfunction

  task automatic push_touch(input logic [TimeW-1:0] t, input logic p,
                            input logic [RawW-1:0] x, input logic [RawW-1:0] y);
    touch_t s;
    s.time_now = t;
    s.pressed  = p;
    s.raw_x    = x;
    s.raw_y    = y;
    sample_q.push_back(s);
    if (p && stim_next_poll < t) stim_next_poll = t + TimeW'(gap_ticks);
  endtask

  // Mostly samples just past the poll time; the rest are releases, stale
  // times and times right below the wrap point.
  task automatic gen_touch();
    logic [RawW-1:0] x, y;
    int unsigned     roll, r;
    x = rand_raw();
    y = rand_raw();
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      push_touch(stim_next_poll + TimeW'($urandom_range(0, 2 * int'(gap_ticks) + 4)), 1'b1, x, y);
    end else if (roll < 82) begin
      push_touch($urandom, 1'b0, x, y);
    end else if (roll < 94) begin
      r = $urandom_range(0, gap_ticks);
      if (r > stim_next_poll) r = stim_next_poll;
      push_touch(stim_next_poll - TimeW'(r), 1'b1, x, y);
    end else if (gap_ticks != 0) begin
      push_touch({TimeW{1'b1}} - TimeW'($urandom_range(0, int'(gap_ticks) - 1)), 1'b1, x, y);
    end else begin
      push_touch(stim_next_poll + 1, 1'b1, x, y);
    end
  endtask

  task automatic queue_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    reg_write_t w;
    w.index = idx;
    w.data  = d;
    reg_q.push_back(w);
  endtask

  task automatic apply_writes();
    reg_write_t w;
    while (reg_q.size() != 0) begin
      w = reg_q.pop_front();
      cfg_we    <= 1'b1;
      cfg_index <= w.index;
      cfg_data  <= w.data;
      case (w.index)
        REG_COEF_A:   coefs.coef_a = w.data;
        REG_COEF_B:   coefs.coef_b = w.data;
        REG_COEF_C:   coefs.coef_c = w.data;
        REG_COEF_D:   coefs.coef_d = w.data;
        REG_COEF_E:   coefs.coef_e = w.data;
        REG_COEF_F:   coefs.coef_f = w.data;
        REG_DIVISOR:  if (w.data != '0) coefs.divisor = w.data;
        REG_POLL_GAP: gap_ticks = w.data[GapW-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || cal_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (sample_q.size() != 0) begin
        next_touch = sample_q.pop_front();
        time_now <= next_touch.time_now;
        pressed  <= next_touch.pressed;
        raw_x    <= next_touch.raw_x;
        raw_y    <= next_touch.raw_y;
        in_valid <= 1'b1;
        in_wait = draw_wait(in_idle_on);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : predict_points
    point_t pt;
    if (!rst && in_valid && in_ready) begin
      in_taken = 1'b1;
      if (pressed && next_poll < time_now) begin
        next_poll = time_now + TimeW'(gap_ticks);
        pt.cal_x = affine_axis(coefs.coef_a, coefs.coef_b, coefs.coef_c, coefs.divisor,
                               raw_x, raw_y);
        pt.cal_y = affine_axis(coefs.coef_d, coefs.coef_e, coefs.coef_f, coefs.divisor,
                               raw_x, raw_y);
        cal_q.push_back(pt);
      end
    end
  end

  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && out_valid && out_ready) begin
      out_wait = draw_wait(out_idle_on);
      if (cal_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, cal_x %h cal_y %h", $time, cal_x, cal_y);
      end else begin
        want = cal_q.pop_front();
        if (cal_x !== want.cal_x) begin
          errors++;
          $display("%0t: cal_x expected %h, got %h", $time, want.cal_x, cal_x);
        end
        if (cal_y !== want.cal_y) begin
          errors++;
          $display("%0t: cal_y expected %h, got %h", $time, want.cal_y, cal_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, cal_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    int batch;
    bit narrow;
    coefs = '{coef_a: 1, coef_b: 0, coef_c: 0, coef_d: 1, coef_e: 0, coef_f: 0, divisor: 1};
    gap_ticks      = PollGapReset;
    next_poll      = '0;
    stim_next_poll = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Identity setting: equal times, a release and full-scale raw values.
    push_touch(32'd0, 1'b1, 16'h0000, 16'h0000);
    push_touch(32'd1, 1'b1, 16'hFFFF, 16'hFFFF);
    push_touch(32'd500, 1'b0, 16'hFFFF, 16'h0000);
    push_touch(32'd101, 1'b1, 16'h0000, 16'hFFFF);
    push_touch(32'd102, 1'b1, 16'h1234, 16'h4321);
    wait_idle();

    queue_write(REG_COEF_A, CoefMax);
    queue_write(REG_COEF_B, CoefMin);
    queue_write(REG_COEF_C, CoefMax);
    queue_write(REG_COEF_D, CoefMin);
    queue_write(REG_COEF_E, CoefMax);
    queue_write(REG_COEF_F, CoefMin);
    queue_write(REG_DIVISOR, '1);
    queue_write(REG_POLL_GAP, '0);
    apply_writes();
    push_touch(32'd203, 1'b1, 16'hFFFF, 16'h0000);
    push_touch(32'd204, 1'b1, 16'h0000, 16'hFFFF);
    push_touch(32'd205, 1'b1, 16'hFFFF, 16'hFFFF);
    push_touch(32'd206, 1'b1, 16'h0000, 16'h0000);
    push_touch(32'd206, 1'b1, 16'h0005, 16'h0005);
    wait_idle();

    // The zero divisor and the indexes past the register list are dropped.
    queue_write(REG_DIVISOR, CoefMin);
    queue_write(REG_DIVISOR, '0);
    queue_write(CfgIdxW'(REG_POLL_GAP) + CfgIdxW'(2), $urandom);
    queue_write('1, '1);
    queue_write(REG_POLL_GAP, 32'h0000_FFFF);
    apply_writes();
    push_touch(32'd207, 1'b1, 16'hFFFF, 16'h0001);
    push_touch(32'd208, 1'b1, 16'h0001, 16'h0001);
    push_touch(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    push_touch(32'h0000_FFFF, 1'b1, 16'h0000, 16'hFFFF);
    wait_idle();

    // Small signed weights show truncation of negative quotients.
    queue_write(REG_COEF_A, -32'sd7);
    queue_write(REG_COEF_B, 32'sd3);
    queue_write(REG_COEF_C, -32'sd5);
    queue_write(REG_COEF_D, 32'sd5);
    queue_write(REG_COEF_E, -32'sd3);
    queue_write(REG_COEF_F, 32'sd2);
    queue_write(REG_DIVISOR, -32'sd4);
    queue_write(REG_POLL_GAP, 32'd1);
    apply_writes();
    push_touch(32'h0002_0000, 1'b1, 16'h0003, 16'h0001);
    push_touch(32'h0002_0001, 1'b1, 16'h0001, 16'h0007);
    push_touch(32'h0002_0002, 1'b1, 16'hFFFF, 16'hFFFF);
    push_touch(32'h0002_0004, 1'b1, 16'h0002, 16'h0000);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_idle();
      narrow = (ph % 2) == 1;
      if ($urandom_range(0, 2) == 0) queue_write(REG_DIVISOR, '0);
      queue_write(CfgIdxW'(REG_POLL_GAP) + CfgIdxW'($urandom_range(1, 8)), $urandom);
      queue_write(REG_COEF_A, rand_coef(narrow));
      queue_write(REG_COEF_B, rand_coef(narrow));
      queue_write(REG_COEF_C, rand_coef(narrow));
      queue_write(REG_COEF_D, rand_coef(narrow));
      queue_write(REG_COEF_E, rand_coef(narrow));
      queue_write(REG_COEF_F, rand_coef(narrow));
      queue_write(REG_DIVISOR, rand_divisor(narrow));
      queue_write(REG_POLL_GAP, rand_gap());
      apply_writes();
      in_idle_on  = (ph % 4 == 0) || (ph % 4 == 2);
      out_idle_on = (ph % 4 == 0) || (ph % 4 == 1);
      sent = 0;
      while (sent < PhaseItems) begin
        batch = $urandom_range(1, 40);
        repeat (batch) gen_touch();
        sent += batch;
        if ($urandom_range(0, 4) == 0) wait_idle();
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tac_pkg.sv
hw/rtl/tac_front.sv
hw/rtl/tac_queue.sv
hw/rtl/tac_back.sv
hw/rtl/touch_affine_calibrate_unit.sv
dv/touch_affine_calibrate_unit_tb.sv
